// ===== rtl/ies_pkg.sv =====
// ----------------------------------------------------------------------------
// ies_pkg
// shared widths, constants and types of the isotropic elastic stress core
// ----------------------------------------------------------------------------
package ies_pkg;

    localparam int STRAIN_W  = 32;
    localparam int STRESS_W  = 64;
    localparam int COEF_W    = 56;
    localparam int LAME_W    = 57;
    localparam int YM_W      = 32;
    localparam int NU_W      = 17;

    localparam int S_DATA_W  = 6 * STRAIN_W;
    localparam int M_DATA_W  = 560;

    // serial divider: quotient of (num * 2^FRAC) / den
    localparam int DIV_NUM_W = 50;
    localparam int DIV_DEN_W = 36;
    localparam int DIV_FRAC  = 32;
    localparam int DIV_STEPS = DIV_NUM_W + DIV_FRAC;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int DIV_Q_W   = COEF_W + 1;

    localparam int ONE_Q16   = 65536;
    localparam int HALF_Q16  = 32768;

    localparam logic [YM_W-1:0] YM_RESET = 32'd1;
    localparam logic [NU_W-1:0] NU_RESET = 17'd19661;

    // register indexes
    localparam logic REG_YM = 1'b0;
    localparam logic REG_NU = 1'b1;

    typedef enum logic [2:0] {
        CS_PREP,
        CS_LOAD,
        CS_RUN,
        CS_FIN,
        CS_IDLE
    } t_cstate;

endpackage

// ===== rtl/isotropic_elastic_stress_core.sv =====
// ----------------------------------------------------------------------------
// isotropic_elastic_stress_core
// hooke's law for an isotropic solid, six voigt strains in, six stresses out
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one strain word (six Q1.30 components), m_axis one stress
//   word (six Q48.16 stresses plus the three Q40.16 coefficients), with the
//   status flag in tuser. the apb port holds E (0x0) and nu (0x4).
//   a word accepted from s_axis moves through the stage registers r_v1,
//   r_v2, r_v3 and r_v4 and is shown on m_axis from r_v4; one word is
//   accepted every cycle while the sequencer is idle and m_axis does not
//   stall. each stage holds its word until the next stage frees, so a
//   stall on m_axis fills the bubbles first and then drops s_axis_tready;
//   nothing is lost or repeated. the coefficients are worked out by three
//   serial dividers after reset and after every register write, while
//   s_axis_tready is low: the products are registered, the dividers load,
//   run their 82 divide steps, the sequencer sees all three done, and the
//   coefficients are captured.
//   reset empties the pipeline and loads E=1, nu=19661.
// ----------------------------------------------------------------------------
module isotropic_elastic_stress_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // strain_xx, strain_yy, strain_zz, strain_yz, strain_zx, strain_xy
    input  logic [ies_pkg::S_DATA_W-1:0]     s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // stress_xx, stress_yy, stress_zz, stress_yz, stress_zx, stress_xy,
    // diagonal_stiffness, lame_stiffness, shear_stiffness, zero pad
    output logic [ies_pkg::M_DATA_W-1:0]     m_axis_tdata,
    // status
    output logic                             m_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    // ---------------- configuration ----------------
    logic [ies_pkg::YM_W-1:0]        r_ym;
    logic signed [ies_pkg::NU_W-1:0] r_nu;
    logic                            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ym <= ies_pkg::YM_RESET;
            r_nu <= ies_pkg::NU_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                ies_pkg::REG_YM: r_ym <= pwdata;
                ies_pkg::REG_NU: r_nu <= pwdata[ies_pkg::NU_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            ies_pkg::REG_YM: prdata = r_ym;
            ies_pkg::REG_NU: prdata = {15'b0, r_nu};
            default:         prdata = '0;
        endcase
    end

    // ---------------- coefficient sequencer ----------------
    ies_pkg::t_cstate r_state, n_state;
    logic start, capture, idle;
    logic d_busy, l_busy, s_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ies_pkg::CS_PREP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        if (cfg_wr) begin
            n_state = ies_pkg::CS_PREP;
        end else begin
            unique case (r_state)
                ies_pkg::CS_PREP: n_state = ies_pkg::CS_LOAD;
                ies_pkg::CS_LOAD: n_state = ies_pkg::CS_RUN;
                ies_pkg::CS_RUN: begin
                    if (!(d_busy || l_busy || s_busy)) n_state = ies_pkg::CS_FIN;
                end
                ies_pkg::CS_FIN:  n_state = ies_pkg::CS_IDLE;
                ies_pkg::CS_IDLE: n_state = ies_pkg::CS_IDLE;
                default:          n_state = ies_pkg::CS_PREP;
            endcase
        end
    end

    always_comb begin
        start   = (r_state == ies_pkg::CS_LOAD);
        capture = (r_state == ies_pkg::CS_FIN);
        idle    = (r_state == ies_pkg::CS_IDLE);
    end

    // numerators and denominators, registered before the dividers load
    logic signed [ies_pkg::NU_W+1:0] nu_x;
    logic [ies_pkg::NU_W-1:0]        den1_c, a_c;
    logic [ies_pkg::NU_W:0]          b_c;
    logic [ies_pkg::NU_W-2:0]        absnu_c;
    logic                            inv_c;

    logic [ies_pkg::YM_W+ies_pkg::NU_W-1:0] num_d_c;
    logic [ies_pkg::YM_W+ies_pkg::NU_W-2:0] num_l_c;
    logic [2*ies_pkg::NU_W:0]               den_d_c;

    logic [ies_pkg::DIV_NUM_W-1:0]   r_num_d, r_num_l, r_num_s;
    logic [ies_pkg::DIV_DEN_W-1:0]   r_den_d, r_den_s;
    logic                            r_inv, r_lneg;

    always_comb begin
        nu_x    = (ies_pkg::NU_W+2)'(r_nu);
        den1_c  = ies_pkg::NU_W'(nu_x + (ies_pkg::NU_W+2)'(ies_pkg::ONE_Q16));
        a_c     = ies_pkg::NU_W'((ies_pkg::NU_W+2)'(ies_pkg::ONE_Q16) - nu_x);
        b_c     = (ies_pkg::NU_W+1)'((ies_pkg::NU_W+2)'(ies_pkg::ONE_Q16)
                  - (nu_x <<< 1));
        absnu_c = r_nu[ies_pkg::NU_W-1] ? (ies_pkg::NU_W-1)'(-nu_x)
                                        : r_nu[ies_pkg::NU_W-2:0];
        inv_c   = (r_ym == '0)
               || (nu_x <= -(ies_pkg::NU_W+2)'(ies_pkg::ONE_Q16))
               || (nu_x >= (ies_pkg::NU_W+2)'(ies_pkg::HALF_Q16));
        num_d_c = r_ym * a_c;
        num_l_c = r_ym * absnu_c;
        den_d_c = den1_c * b_c;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ies_pkg::CS_PREP) begin
            r_num_d <= ies_pkg::DIV_NUM_W'(num_d_c);
            r_num_l <= ies_pkg::DIV_NUM_W'(num_l_c);
            r_num_s <= ies_pkg::DIV_NUM_W'(r_ym);
            r_den_d <= ies_pkg::DIV_DEN_W'(den_d_c);
            r_den_s <= ies_pkg::DIV_DEN_W'(den1_c);
            r_inv   <= inv_c;
            r_lneg  <= r_nu[ies_pkg::NU_W-1];
        end
    end

    logic [ies_pkg::DIV_Q_W-1:0] d_q, l_q, s_q;
    logic                        d_ovf, l_ovf, s_ovf;

    ies_div u_div_diag (
        .i_clk, .i_rst_n, .i_start(start), .i_num(r_num_d), .i_den(r_den_d),
        .o_busy(d_busy), .o_quot(d_q), .o_ovf(d_ovf)
    );
    ies_div u_div_lame (
        .i_clk, .i_rst_n, .i_start(start), .i_num(r_num_l), .i_den(r_den_d),
        .o_busy(l_busy), .o_quot(l_q), .o_ovf(l_ovf)
    );
    ies_div u_div_shear (
        .i_clk, .i_rst_n, .i_start(start), .i_num(r_num_s), .i_den(r_den_s),
        .o_busy(s_busy), .o_quot(s_q), .o_ovf(s_ovf)
    );

    // saturated coefficients, zero when the material is invalid
    logic [ies_pkg::COEF_W-1:0]        r_diag, r_shear;
    logic signed [ies_pkg::LAME_W-1:0] r_lame;
    logic                              r_status;
    logic [ies_pkg::LAME_W-1:0]        lmag;

    always_comb begin
        if (l_ovf || l_q[ies_pkg::DIV_Q_W-1]) begin
            lmag = r_lneg ? {1'b1, {ies_pkg::COEF_W{1'b0}}}
                          : {1'b0, {ies_pkg::COEF_W{1'b1}}};
        end else begin
            lmag = l_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_status <= r_inv;
            if (r_inv) begin
                r_diag  <= '0;
                r_shear <= '0;
                r_lame  <= '0;
            end else begin
                r_diag  <= (d_ovf || d_q[ies_pkg::DIV_Q_W-1]) ? '1
                           : d_q[ies_pkg::COEF_W-1:0];
                r_shear <= (s_ovf || s_q[ies_pkg::DIV_Q_W-1]) ? '1
                           : s_q[ies_pkg::COEF_W-1:0];
                r_lame  <= r_lneg ? -lmag : lmag;
            end
        end
    end

    // ---------------- stress pipeline ----------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    assign en4 = !r_v4 || m_axis_tready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign s_axis_tready = idle && en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= s_axis_tvalid && s_axis_tready;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    logic signed [ies_pkg::STRAIN_W-1:0] r_s1   [6];
    logic signed [ies_pkg::STRAIN_W:0]   r_sum1 [3];

    logic signed [64:0] r_dlo2 [3];
    logic signed [56:0] r_dhi2 [3];
    logic signed [65:0] r_llo2 [3];
    logic signed [57:0] r_lhi2 [3];
    logic signed [64:0] r_slo2 [3];
    logic signed [56:0] r_shi2 [3];

    logic signed [89:0] r_d3  [3];
    logic signed [89:0] r_l3  [3];
    logic signed [89:0] r_sh3 [3];

    logic signed [ies_pkg::STRESS_W-1:0] r_n4 [3];
    logic signed [ies_pkg::STRESS_W-1:0] r_t4 [3];

    logic signed [ies_pkg::STRAIN_W-1:0] in_s [6];
    logic signed [89:0]                  nsum [3];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            in_s[k] = s_axis_tdata[k*ies_pkg::STRAIN_W +: ies_pkg::STRAIN_W];
        end
        for (int k = 0; k < 3; k++) begin
            nsum[k] = r_d3[k] + r_l3[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && s_axis_tvalid && s_axis_tready) begin
            for (int k = 0; k < 6; k++) r_s1[k] <= in_s[k];
            for (int k = 0; k < 3; k++) begin
                r_sum1[k] <= (ies_pkg::STRAIN_W+1)'(in_s[(k+1)%3])
                           + (ies_pkg::STRAIN_W+1)'(in_s[(k+2)%3]);
            end
        end
        if (en2 && r_v1) begin
            for (int k = 0; k < 3; k++) begin
                r_dlo2[k] <= $signed({1'b0, r_diag[31:0]}) * r_s1[k];
                r_dhi2[k] <= $signed({1'b0, r_diag[55:32]}) * r_s1[k];
                r_llo2[k] <= $signed({1'b0, r_lame[31:0]}) * r_sum1[k];
                r_lhi2[k] <= $signed(r_lame[56:32]) * r_sum1[k];
                r_slo2[k] <= $signed({1'b0, r_shear[31:0]}) * r_s1[k+3];
                r_shi2[k] <= $signed({1'b0, r_shear[55:32]}) * r_s1[k+3];
            end
        end
        if (en3 && r_v2) begin
            for (int k = 0; k < 3; k++) begin
                r_d3[k]  <= 90'(r_dlo2[k]) + (90'(r_dhi2[k]) <<< 32);
                r_l3[k]  <= 90'(r_llo2[k]) + (90'(r_lhi2[k]) <<< 32);
                r_sh3[k] <= 90'(r_slo2[k]) + (90'(r_shi2[k]) <<< 32);
            end
        end
        if (en4 && r_v3) begin
            // floor by 2^30; the result always fits 64 bits
            for (int k = 0; k < 3; k++) begin
                r_n4[k] <= ies_pkg::STRESS_W'(nsum[k] >>> 30);
                r_t4[k] <= ies_pkg::STRESS_W'(r_sh3[k] >>> 30);
            end
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {7'b0, r_shear, r_lame, r_diag,
                            r_t4[2], r_t4[1], r_t4[0],
                            r_n4[2], r_n4[1], r_n4[0]};

endmodule

// ===== rtl/ies_div.sv =====
// ----------------------------------------------------------------------------
// ies_div
// restoring divider, one quotient bit per cycle, overflow past COEF_W+1 bits
// ----------------------------------------------------------------------------
module ies_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [ies_pkg::DIV_NUM_W-1:0]     i_num,
    input  logic [ies_pkg::DIV_DEN_W-1:0]     i_den,
    output logic                              o_busy,
    output logic [ies_pkg::DIV_Q_W-1:0]       o_quot,
    output logic                              o_ovf
);

    logic [ies_pkg::DIV_STEPS-1:0] r_shift;
    logic [ies_pkg::DIV_DEN_W-1:0] r_den;
    logic [ies_pkg::DIV_DEN_W-1:0] r_rem;
    logic [ies_pkg::DIV_Q_W-1:0]   r_quot;
    logic                          r_ovf;
    logic [ies_pkg::DIV_CNT_W-1:0] r_cnt;

    logic [ies_pkg::DIV_DEN_W:0]   trial;
    logic                          qbit;
    logic [ies_pkg::DIV_DEN_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_shift[ies_pkg::DIV_STEPS-1]};
        qbit  = (trial >= {1'b0, r_den});
        n_rem = qbit ? ies_pkg::DIV_DEN_W'(trial - {1'b0, r_den})
                     : ies_pkg::DIV_DEN_W'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= ies_pkg::DIV_CNT_W'(ies_pkg::DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= {i_num, {ies_pkg::DIV_FRAC{1'b0}}};
            r_den   <= i_den;
            r_rem   <= '0;
            r_quot  <= '0;
            r_ovf   <= 1'b0;
        end else if (r_cnt != '0) begin
            r_shift <= {r_shift[ies_pkg::DIV_STEPS-2:0], 1'b0};
            r_rem   <= n_rem;
            r_quot  <= {r_quot[ies_pkg::DIV_Q_W-2:0], qbit};
            r_ovf   <= r_ovf | r_quot[ies_pkg::DIV_Q_W-1];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;

endmodule

// ===== rtl/ies_chk.sv =====
// ----------------------------------------------------------------------------
// ies_chk
// port-level checks of the isotropic elastic stress core
// ----------------------------------------------------------------------------
module ies_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tready,
    input logic [ies_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic                         m_axis_tuser,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready
);

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

    // invalid material gives an all-zero word
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("invalid status with nonzero data");

    // valid material always has nonzero diagonal and shear terms
    a_coef_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser
        |-> m_axis_tdata[439:384] != '0 && m_axis_tdata[552:497] != '0)
        else $error("zero stiffness on valid material");

    // nothing leaves the pipe and no word is accepted right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("pipeline not empty after reset");

endmodule

bind isotropic_elastic_stress_core ies_chk u_ies_chk (.*);
